### hdl/volume_curve_mapper_core_assert.svh
// Assertion macros used by the checker file of the volume curve mapper.
// No dependencies; include by bare file name.
`ifndef VOLUME_CURVE_MAPPER_CORE_ASSERT_SVH
`define VOLUME_CURVE_MAPPER_CORE_ASSERT_SVH

// same-cycle implication, masked during reset
`define VCM_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("volume curve mapper: implication check failed");

// next-cycle implication, masked during reset
`define VCM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("volume curve mapper: next-cycle check failed");

// next-cycle implication, checked through reset
`define VCM_ASSERT_NEXT_RST(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("volume curve mapper: reset check failed");

`endif

### hdl/vcm_pkg.sv
// Package of the volume curve mapper: widths, codes, word types and curve tables.
// No dependencies.
package vcm_pkg;

    localparam int FRAC_BITS = 16;
    localparam int RAW_W     = 16;
    localparam int TAB_W     = FRAC_BITS + 1;
    localparam int TAB_N     = 101;
    localparam int PCT_MAX   = 100;
    localparam int PCT_W     = 7;
    localparam int QW        = (TAB_W > RAW_W) ? TAB_W : RAW_W;
    localparam int NUM_W     = RAW_W + QW;
    localparam int PROD_W    = TAB_W + RAW_W;
    localparam int CNT_W     = 7;
    localparam int SRCH_STEPS = 7;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_RAW_MIN     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RAW_MAX     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CURVE       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MUTE_FOLLOW = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HAS_SWITCH  = 3'd4;

    localparam logic [1:0] CURVE_LIN = 2'd0;
    localparam logic [1:0] CURVE_LOG = 2'd1;
    localparam logic [1:0] CURVE_EXP = 2'd2;

    localparam int TAB_LF = 0;
    localparam int TAB_LT = 1;
    localparam int TAB_EF = 2;
    localparam int TAB_ET = 3;

    // scale factors for the table math
    localparam real INV_LN101 = 1.0 / $ln(101.0);
    localparam real INV_PCT   = 1.0 / 100.0;

    typedef logic [TAB_W-1:0] t_tab [0:TAB_N-1];

    // Q(FRAC_BITS) fractions, rounded to nearest, worked out at elaboration
    function automatic t_tab build_tab(input int kind);
        t_tab tab;
        real  x;
        real  one;
        one = real'(1 << FRAC_BITS);
        for (int k = 0; k < TAB_N; k++) begin
            case (kind)
                TAB_LF:  x = $ln(real'(k) + 1.0) * INV_LN101;
                TAB_LT:  x = (k == 0) ? 0.0 : $ln(real'(k) + 0.5) * INV_LN101;
                TAB_EF:  x = $pow(2.0, real'(k) * INV_PCT) - 1.0;
                default: x = (k == 0) ? 0.0 : $pow(2.0, (real'(k) - 0.5) * INV_PCT) - 1.0;
            endcase
            tab[k] = TAB_W'($rtoi(x * one + 0.5));
        end
        return tab;
    endfunction

    localparam t_tab LF_TAB = build_tab(TAB_LF);
    localparam t_tab LT_TAB = build_tab(TAB_LT);
    localparam t_tab EF_TAB = build_tab(TAB_EF);
    localparam t_tab ET_TAB = build_tab(TAB_ET);

    typedef enum logic [2:0] {
        M_PASS,
        M_RD_LIN,
        M_RD_CRV,
        M_WR_LIN,
        M_WR_CRV
    } t_mode;

    typedef struct packed {
        logic signed [RAW_W-1:0] raw_min;
        logic signed [RAW_W-1:0] raw_max;
        logic [1:0]              curve;
        logic                    mute_follow;
        logic                    has_switch;
    } t_cfg;

    // per-word sideband that rides along every stage
    typedef struct packed {
        t_mode                   mode;
        logic                    use_log;
        logic                    func;
        logic signed [RAW_W-1:0] lo;
        logic signed [RAW_W-1:0] val;
        logic [PROD_W-1:0]       prod;
    } t_side;

    // divider state: partial remainder, unconsumed dividend / quotient bits, divisor
    typedef struct packed {
        logic [RAW_W-1:0] rem;
        logic [QW-1:0]    nlow;
        logic [RAW_W-1:0] den;
    } t_div;

endpackage

### hdl/vcm_front.sv
// Front stages: clamp and classify, then build dividend/divisor or table product.
// Depends on vcm_pkg.
module vcm_front
    import vcm_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  logic                    i_func,
    input  logic signed [RAW_W-1:0] i_value,
    input  t_cfg                    i_cfg,
    output logic                    o_valid,
    output t_side                   o_side,
    output t_div                    o_div
);

    // stage A
    logic                    r_a_valid;
    t_mode                   r_a_mode, n_a_mode;
    logic                    r_a_use_log, n_a_use_log;
    logic                    r_a_func;
    logic signed [RAW_W-1:0] r_a_lo, r_a_val;
    logic [RAW_W-1:0]        r_a_d, n_a_d, r_a_s, n_a_s;
    logic [PCT_W-1:0]        r_a_p, n_a_p;

    logic signed [RAW_W-1:0] clamped;
    logic                    empty, crv;

    always_comb begin
        empty   = i_cfg.raw_max <= i_cfg.raw_min;
        crv     = (i_cfg.curve == CURVE_LOG) || (i_cfg.curve == CURVE_EXP);
        clamped = (i_value < i_cfg.raw_min) ? i_cfg.raw_min :
                  (i_value > i_cfg.raw_max) ? i_cfg.raw_max : i_value;
        n_a_d   = clamped - i_cfg.raw_min;
        n_a_s   = i_cfg.raw_max - i_cfg.raw_min;
        if (i_value < 0) begin
            n_a_p = '0;
        end else if (i_value > RAW_W'(PCT_MAX)) begin
            n_a_p = PCT_W'(PCT_MAX);
        end else begin
            n_a_p = i_value[PCT_W-1:0];
        end
        n_a_use_log = i_cfg.curve == CURVE_LOG;
        if (empty) begin
            n_a_mode = M_PASS;
        end else if (i_func) begin
            n_a_mode = crv ? M_WR_CRV : M_WR_LIN;
        end else begin
            n_a_mode = crv ? M_RD_CRV : M_RD_LIN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (i_en) begin
            r_a_valid <= i_valid;
        end
        if (i_en) begin
            r_a_mode    <= n_a_mode;
            r_a_use_log <= n_a_use_log;
            r_a_func    <= i_func;
            r_a_lo      <= i_cfg.raw_min;
            r_a_val     <= i_value;
            r_a_d       <= n_a_d;
            r_a_s       <= n_a_s;
            r_a_p       <= n_a_p;
        end
    end

    // stage B
    logic              r_b_valid;
    t_side             r_b_side, n_b_side;
    t_div              r_b_div, n_b_div;
    logic [NUM_W-1:0]  num;
    logic [RAW_W-1:0]  den;
    logic [TAB_W-1:0]  frac;

    always_comb begin
        frac = r_a_use_log ? LF_TAB[r_a_p] : EF_TAB[r_a_p];
        case (r_a_mode)
            M_RD_LIN: begin
                num = NUM_W'(r_a_d) * NUM_W'(PCT_MAX) + NUM_W'(r_a_s) - NUM_W'(1);
                den = r_a_s;
            end
            M_RD_CRV: begin
                num = NUM_W'({r_a_d, {FRAC_BITS{1'b0}}});
                den = r_a_s;
            end
            M_WR_LIN: begin
                num = NUM_W'(r_a_p) * NUM_W'(r_a_s);
                den = RAW_W'(PCT_MAX);
            end
            default: begin
                num = '0;
                den = RAW_W'(1);
            end
        endcase
        n_b_div.rem  = RAW_W'(num >> QW);
        n_b_div.nlow = num[QW-1:0];
        n_b_div.den  = den;
        n_b_side.mode    = r_a_mode;
        n_b_side.use_log = r_a_use_log;
        n_b_side.func    = r_a_func;
        n_b_side.lo      = r_a_lo;
        n_b_side.val     = r_a_val;
        n_b_side.prod    = PROD_W'(frac) * PROD_W'(r_a_s);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (i_en) begin
            r_b_valid <= r_a_valid;
        end
        if (i_en) begin
            r_b_side <= n_b_side;
            r_b_div  <= n_b_div;
        end
    end

    assign o_valid = r_b_valid;
    assign o_side  = r_b_side;
    assign o_div   = r_b_div;

endmodule

### hdl/vcm_div.sv
// Pipelined restoring divider, one quotient bit per stage.
// Depends on vcm_pkg.
module vcm_div
    import vcm_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  t_side         i_side,
    input  t_div          i_div,
    output logic          o_valid,
    output t_side         o_side,
    output logic [QW-1:0] o_quot
);

    logic  r_valid [QW];
    t_side r_side  [QW];
    t_div  r_div   [QW];

    for (genvar j = 0; j < QW; j++) begin : g_stage
        logic          in_valid;
        t_side         in_side;
        t_div          in_div, n_div;
        logic [RAW_W:0] trial;
        logic          ge;

        if (j == 0) begin : g_first
            assign in_valid = i_valid;
            assign in_side  = i_side;
            assign in_div   = i_div;
        end else begin : g_next
            assign in_valid = r_valid[j-1];
            assign in_side  = r_side[j-1];
            assign in_div   = r_div[j-1];
        end

        always_comb begin
            trial      = {in_div.rem, in_div.nlow[QW-1]};
            ge         = trial >= {1'b0, in_div.den};
            n_div.rem  = ge ? RAW_W'(trial - {1'b0, in_div.den}) : trial[RAW_W-1:0];
            n_div.nlow = {in_div.nlow[QW-2:0], ge};
            n_div.den  = in_div.den;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[j] <= 1'b0;
            end else if (i_en) begin
                r_valid[j] <= in_valid;
            end
            if (i_en) begin
                r_side[j] <= in_side;
                r_div[j]  <= n_div;
            end
        end
    end

    assign o_valid = r_valid[QW-1];
    assign o_side  = r_side[QW-1];
    assign o_quot  = r_div[QW-1].nlow;

endmodule

### hdl/vcm_search.sv
// Pipelined binary search counting curve thresholds at or below the scaled ratio.
// Depends on vcm_pkg.
module vcm_search
    import vcm_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  t_side            i_side,
    input  logic [QW-1:0]    i_quot,
    output logic             o_valid,
    output t_side            o_side,
    output logic [QW-1:0]    o_quot,
    output logic [CNT_W-1:0] o_cnt
);

    logic             r_valid [SRCH_STEPS];
    t_side            r_side  [SRCH_STEPS];
    logic [QW-1:0]    r_quot  [SRCH_STEPS];
    logic [CNT_W-1:0] r_cnt   [SRCH_STEPS];

    for (genvar j = 0; j < SRCH_STEPS; j++) begin : g_stage
        localparam logic [CNT_W-1:0] STEP = CNT_W'(1 << (SRCH_STEPS - 1 - j));

        logic             in_valid;
        t_side            in_side;
        logic [QW-1:0]    in_quot;
        logic [CNT_W-1:0] in_cnt, idx, sel, n_cnt;
        logic [TAB_W-1:0] thr;
        logic             in_range, hit;

        if (j == 0) begin : g_first
            assign in_valid = i_valid;
            assign in_side  = i_side;
            assign in_quot  = i_quot;
            assign in_cnt   = '0;
        end else begin : g_next
            assign in_valid = r_valid[j-1];
            assign in_side  = r_side[j-1];
            assign in_quot  = r_quot[j-1];
            assign in_cnt   = r_cnt[j-1];
        end

        always_comb begin
            idx      = in_cnt + STEP;
            in_range = idx <= CNT_W'(PCT_MAX);
            sel      = in_range ? idx : CNT_W'(PCT_MAX);
            thr      = in_side.use_log ? LT_TAB[sel] : ET_TAB[sel];
            hit      = in_range && (QW'(thr) <= in_quot);
            n_cnt    = hit ? idx : in_cnt;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[j] <= 1'b0;
            end else if (i_en) begin
                r_valid[j] <= in_valid;
            end
            if (i_en) begin
                r_side[j] <= in_side;
                r_quot[j] <= in_quot;
                r_cnt[j]  <= n_cnt;
            end
        end
    end

    assign o_valid = r_valid[SRCH_STEPS-1];
    assign o_side  = r_side[SRCH_STEPS-1];
    assign o_quot  = r_quot[SRCH_STEPS-1];
    assign o_cnt   = r_cnt[SRCH_STEPS-1];

endmodule

### hdl/volume_curve_mapper_core.sv
// Throughput: one word per cycle when not stalled; the 17-stage divider and 7-stage search are fully pipelined.
// A stalled output freezes the whole pipeline; a word is never dropped or repeated.
// Reset (synchronous, active low) clears all valid bits and loads the register defaults:
// raw_min 0, raw_max 100, linear curve, mute follow on, no switch. No clearing pass is needed.
// Depends on vcm_pkg, vcm_front, vcm_div, vcm_search.
module volume_curve_mapper_core
    import vcm_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // configuration write port
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [RAW_W-1:0]        i_cfg_data,
    // input channel
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic                    i_func,
    input  logic signed [RAW_W-1:0] i_value,
    // output channel
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic signed [RAW_W-1:0] o_result,
    output logic                    o_switch_write,
    output logic                    o_switch_on
);

    // ------------------------------------------------------------------
    // Configuration registers. The user must write them only while the pipe is
    // idle (the block itself leaves this unenforced), so every stage may read them live.
    // ------------------------------------------------------------------
    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.raw_min     <= '0;
            r_cfg.raw_max     <= RAW_W'(PCT_MAX);
            r_cfg.curve       <= CURVE_LIN;
            r_cfg.mute_follow <= 1'b1;
            r_cfg.has_switch  <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_RAW_MIN:     r_cfg.raw_min     <= i_cfg_data;
                CFG_RAW_MAX:     r_cfg.raw_max     <= i_cfg_data;
                CFG_CURVE:       r_cfg.curve       <= i_cfg_data[1:0];
                CFG_MUTE_FOLLOW: r_cfg.mute_follow <= i_cfg_data[0];
                CFG_HAS_SWITCH:  r_cfg.has_switch  <= i_cfg_data[0];
                default: ;      // indexes past the list are ignored
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Global advance: every stage moves when the output register is free
    // or is being drained this cycle. Bubbles ride along; input is taken
    // whenever the pipe moves.
    // ------------------------------------------------------------------
    logic r_out_valid;
    logic en;

    assign en         = !r_out_valid || !i_out_stall;
    assign o_in_stall = !en;

    // front: clamp / classify, then dividend+divisor or Q16 table product
    logic  fr_valid;
    t_side fr_side;
    t_div  fr_div;

    vcm_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_in_valid),
        .i_func  (i_func),
        .i_value (i_value),
        .i_cfg   (r_cfg),
        .o_valid (fr_valid),
        .o_side  (fr_side),
        .o_div   (fr_div)
    );

    // divider: ceil(100d/S) for linear reads, floor(d*2^F/S) for curve
    // reads, floor(p*S/100) for linear writes
    logic          dv_valid;
    t_side         dv_side;
    logic [QW-1:0] dv_quot;

    vcm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (fr_valid),
        .i_side  (fr_side),
        .i_div   (fr_div),
        .o_valid (dv_valid),
        .o_side  (dv_side),
        .o_quot  (dv_quot)
    );

    // threshold count for curve reads: since the thresholds are integers,
    // d*2^F >= T*S holds exactly when floor(d*2^F/S) >= T
    logic             sr_valid;
    t_side            sr_side;
    logic [QW-1:0]    sr_quot;
    logic [CNT_W-1:0] sr_cnt;

    vcm_search u_search (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (dv_valid),
        .i_side  (dv_side),
        .i_quot  (dv_quot),
        .o_valid (sr_valid),
        .o_side  (sr_side),
        .o_quot  (sr_quot),
        .o_cnt   (sr_cnt)
    );

    // ------------------------------------------------------------------
    // Result select and output register
    // ------------------------------------------------------------------
    logic [RAW_W-1:0]  n_result, r_result;
    logic [PROD_W-1:0] rnd;
    logic              n_sw_write, n_sw_on, r_sw_write, r_sw_on;

    always_comb begin
        // write on a log/exp curve rounds the product to nearest, ties up
        rnd = sr_side.prod + PROD_W'(1 << (FRAC_BITS - 1));
        case (sr_side.mode)
            M_RD_LIN: n_result = sr_quot[RAW_W-1:0];
            M_RD_CRV: n_result = RAW_W'(sr_cnt);
            M_WR_LIN: n_result = sr_side.lo + sr_quot[RAW_W-1:0];
            M_WR_CRV: n_result = sr_side.lo + RAW_W'(rnd >> FRAC_BITS);
            default:  n_result = sr_side.val;   // empty range: pass through
        endcase
        // switch fields only matter on writes; reads report zeros
        n_sw_write = sr_side.func && r_cfg.mute_follow && r_cfg.has_switch;
        n_sw_on    = sr_side.func && (n_result != '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= sr_valid;
        end
        if (en) begin
            r_result   <= n_result;
            r_sw_write <= n_sw_write;
            r_sw_on    <= n_sw_on;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_result       = r_result;
    assign o_switch_write = r_sw_write;
    assign o_switch_on    = r_sw_on;

endmodule

### hdl/vcm_checker.sv
// Port-level checker for volume_curve_mapper_core, attached by bind.
// Depends on vcm_pkg and volume_curve_mapper_core_assert.svh.
`include "volume_curve_mapper_core_assert.svh"

module vcm_checker
    import vcm_pkg::*;
(
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    o_in_stall,
    input logic                    o_out_valid,
    input logic                    i_out_stall,
    input logic signed [RAW_W-1:0] o_result,
    input logic                    o_switch_on
);

    `VCM_ASSERT_NEXT_RST(a_reset_empties, i_clk, !i_rst_n, !o_out_valid)
    `VCM_ASSERT_IMPLY(a_stall_backs_up, i_clk, i_rst_n, o_out_valid && i_out_stall, o_in_stall)
    `VCM_ASSERT_IMPLY(a_free_when_empty, i_clk, i_rst_n, !o_out_valid, !o_in_stall)
    `VCM_ASSERT_IMPLY(a_switch_on_nonzero, i_clk, i_rst_n, o_out_valid && o_switch_on, o_result != 0)
    `VCM_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_result))

endmodule

bind volume_curve_mapper_core vcm_checker u_vcm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_result    (o_result),
    .o_switch_on (o_switch_on)
);

### tb/testbench.sv
// Self-checking testbench for volume_curve_mapper_core: directed table, then random phases
// under several register settings, checked against an in-bench curve predictor.
// Depends on vcm_pkg and the core RTL.
module testbench
    import vcm_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic FN_READ  = 1'b0;
    localparam logic FN_WRITE = 1'b1;
    localparam int   DRAIN    = 40;   // comfortably above the pipeline depth

    typedef logic [16:0] t_q16;
    typedef struct {
        logic signed [15:0] result;
        logic               sw_write;
        logic               sw_on;
    } t_word_out;
    typedef struct {
        logic               func;
        logic signed [15:0] value;
        bit                 typed;    // result column is filled in
        logic signed [15:0] result;
    } t_row;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]    i_cfg_idx = '0;
    logic [RAW_W-1:0]        i_cfg_data = '0;
    logic                    i_in_valid = 1'b0;
    logic                    o_in_stall;
    logic                    i_func = 1'b0;
    logic signed [RAW_W-1:0] i_value = '0;
    logic                    o_out_valid;
    logic                    i_out_stall = 1'b0;
    logic signed [RAW_W-1:0] o_result;
    logic                    o_switch_write;
    logic                    o_switch_on;

    volume_curve_mapper_core u_dut (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // curve tables, Q16 fractions rounded to nearest
    t_q16 log_frac [0:100];
    t_q16 log_thr  [0:100];
    t_q16 exp_frac [0:100];
    t_q16 exp_thr  [0:100];

    // shadow copy of the register file
    logic signed [15:0] sh_lo = 16'sd0;
    logic signed [15:0] sh_hi = 16'sd100;
    logic [1:0]         sh_curve = CURVE_LIN;
    logic               sh_am = 1'b1;
    logic               sh_hs = 1'b0;

    t_word_out pending_words[$];
    int        mismatches = 0;
    bit        quiet = 0;        // no idling on either side
    bit        hold_req = 0;     // ask the receiver for one long hold-off

    function automatic t_q16 to_q16(input real x);
        return t_q16'($rtoi(x * 65536.0 + 0.5));
    endfunction

    function automatic t_word_out map_word(input logic func, input logic signed [15:0] val);
        t_word_out w;
        int        lo, hi, v, c, p, cnt;
        longint    span, d, add;
        lo = sh_lo;
        hi = sh_hi;
        v  = val;
        w.sw_write = 1'b0;
        w.sw_on    = 1'b0;
        if (hi <= lo) begin
            w.result = val;          // empty range: pass-through, no clamp
        end else begin
            span = hi - lo;
            if (func == FN_READ) begin
                c = (v < lo) ? lo : ((v > hi) ? hi : v);
                d = c - lo;
                if (sh_curve == CURVE_LOG || sh_curve == CURVE_EXP) begin
                    cnt = 0;
                    for (int k = 1; k <= 100; k++)
                        if ((d << 16) >= longint'(sh_curve == CURVE_LOG ? log_thr[k]
                                                                      : exp_thr[k]) * span)
                            cnt++;
                    w.result = 16'(cnt);
                end else begin
                    w.result = 16'((100 * d + span - 1) / span);
                end
            end else begin
                p = (v < 0) ? 0 : ((v > 100) ? 100 : v);
                if (sh_curve == CURVE_LOG || sh_curve == CURVE_EXP)
                    add = (longint'(sh_curve == CURVE_LOG ? log_frac[p] : exp_frac[p]) * span
                           + 32768) >>> 16;
                else
                    add = (p * span) / 100;  // curve code three lands here too
                w.result = 16'(lo + add);
            end
        end
        if (func == FN_WRITE) begin
            w.sw_write = sh_am & sh_hs;
            w.sw_on    = (w.result != 0);
        end
        return w;
    endfunction

    // offer one word and wait until the core takes it; prediction is queued on accept
    task automatic send_word(input logic func, input logic signed [15:0] val,
                             input bit typed, input logic signed [15:0] typed_res);
        t_word_out w;
        bit        taken;
        i_in_valid <= 1'b1;
        i_func     <= func;
        i_value    <= val;
        do begin
            @(negedge i_clk);
            taken = !o_in_stall;
            @(posedge i_clk);
        end while (!taken);
        w = map_word(func, val);
        if (typed)
            w.result = typed_res;
        pending_words.push_back(w);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        wait (pending_words.size() == 0);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_RAW_MIN:     sh_lo    = data;
            CFG_RAW_MAX:     sh_hi    = data;
            CFG_CURVE:       sh_curve = data[1:0];
            CFG_MUTE_FOLLOW: sh_am    = data[0];
            CFG_HAS_SWITCH:  sh_hs    = data[0];
            default: ;
        endcase
    endtask

    task automatic set_all(input int lo, input int hi, input logic [1:0] crv,
                           input logic am, input logic hs);
        write_reg(CFG_RAW_MIN, 16'(lo));
        write_reg(CFG_RAW_MAX, 16'(hi));
        write_reg(CFG_CURVE, {14'd0, crv});
        write_reg(CFG_MUTE_FOLLOW, {15'd0, am});
        write_reg(CFG_HAS_SWITCH, {15'd0, hs});
    endtask

    // mostly in-range raw values / percents, some full-width noise and edges
    task automatic random_words(input int n);
        logic               fn;
        logic signed [15:0] v;
        int                 lo, hi;
        for (int i = 0; i < n; i++) begin
            fn = $urandom_range(0, 1);
            lo = sh_lo;
            hi = sh_hi;
            case ($urandom_range(0, 9))
                0, 1:    v = 16'($urandom);
                2:       v = fn ? 16'($urandom_range(0, 1) ? -1 : 101) : 16'(lo);
                3:       v = fn ? 16'sd100 : 16'(hi);
                default: v = fn ? 16'($urandom_range(0, 100))
                                : (hi > lo ? 16'(lo + int'($urandom_range(0, hi - lo)))
                                           : 16'($urandom));
            endcase
            send_word(fn, v, 1'b0, '0);
        end
    endtask

    // receiver: random stall bursts, one long hold-off on request, none when quiet
    initial begin
        int hold;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 0;
                i_out_stall <= 1'b1;
                hold = 0;
                while (hold < 300) begin
                    @(posedge i_clk);
                    hold++;
                end
                i_out_stall <= 1'b0;
            end else if (quiet || $urandom_range(0, 7) != 0) begin
                i_out_stall <= 1'b0;
            end else begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 14)) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    // result monitor: a word moves at the next rising edge when valid and not stalled
    always @(negedge i_clk) begin
        t_word_out w;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_words.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word: result=%0d sw_write=%0b sw_on=%0b",
                             o_result, o_switch_write, o_switch_on);
            end else begin
                w = pending_words.pop_front();
                if (o_result !== w.result || o_switch_write !== w.sw_write
                        || o_switch_on !== w.sw_on) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp result=%0d sw_write=%0b sw_on=%0b, got %0d %0b %0b",
                                 w.result, w.sw_write, w.sw_on,
                                 o_result, o_switch_write, o_switch_on);
                end
            end
        end
    end

    initial begin
        #2_000_000;
        $display("** volume_curve_mapper_core: FAILED **");
        $finish;
    end

    // directed words under the reset settings: range 0..100, linear, no switch
    t_row rows [0:10] = '{
        '{FN_READ,  -16'sd32768, 1, 16'sd0},    // clamped up to raw_min
        '{FN_READ,   16'sd32767, 1, 16'sd100},  // clamped down to raw_max
        '{FN_READ,   16'sd0,     1, 16'sd0},
        '{FN_READ,   16'sd50,    1, 16'sd50},
        '{FN_READ,   16'sd1,     1, 16'sd1},
        '{FN_WRITE,  16'sd0,     1, 16'sd0},
        '{FN_WRITE,  16'sd100,   1, 16'sd100},
        '{FN_WRITE, -16'sd1,     1, 16'sd0},    // percent clamped to 0
        '{FN_WRITE,  16'sd32767, 1, 16'sd100},
        '{FN_WRITE, -16'sd32768, 1, 16'sd0},
        '{FN_WRITE,  16'sd37,    0, 16'sd0}
    };

    initial begin
        int lo, hi;
        for (int k = 0; k <= 100; k++) begin
            log_frac[k] = to_q16($ln(k + 1.0) / $ln(101.0));
            exp_frac[k] = to_q16($pow(2.0, k / 100.0) - 1.0);
            log_thr[k]  = (k == 0) ? '0 : to_q16($ln(k + 0.5) / $ln(101.0));
            exp_thr[k]  = (k == 0) ? '0 : to_q16($pow(2.0, (k - 0.5) / 100.0) - 1.0);
        end
        log_frac[100] = 17'h10000;
        exp_frac[100] = 17'h10000;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[r])
            send_word(rows[r].func, rows[r].value, rows[r].typed, rows[r].result);
        random_words(30);

        // widest range on both curves, switch present
        wait_idle();
        set_all(-32768, 32767, CURVE_LOG, 1'b1, 1'b1);
        random_words(40);
        wait_idle();
        write_reg(CFG_CURVE, {14'd0, CURVE_EXP});
        random_words(40);

        // inverted range: pass-through
        wait_idle();
        set_all(32767, -32768, CURVE_LIN, 1'b0, 1'b1);
        random_words(30);

        // equal bounds, curve code three
        wait_idle();
        set_all(5, 5, 2'd3, 1'b1, 1'b1);
        random_words(20);

        // small range, curve code three acts linear; long output hold-off midway
        wait_idle();
        set_all(-10, 20, 2'd3, 1'b1, 1'b1);
        random_words(10);
        hold_req = 1;
        random_words(40);

        // random settings, small spans mostly
        for (int ph = 0; ph < 6; ph++) begin
            wait_idle();
            lo = $urandom_range(0, 65535) - 32768;
            hi = ($urandom_range(0, 2) == 0) ? int'($urandom_range(0, 65535)) - 32768
                                             : lo + int'($urandom_range(1, 400));
            if (hi > 32767) hi = 32767;
            if (ph == 5) quiet = 1;
            set_all(lo, hi, 2'($urandom_range(0, 3)), 1'($urandom), 1'($urandom));
            random_words(35);
        end

        i_in_valid <= 1'b0;
        wait (pending_words.size() == 0);
        repeat (DRAIN) @(posedge i_clk);
        if (mismatches == 0)
            $display("** volume_curve_mapper_core: PASSED **");
        else
            $display("** volume_curve_mapper_core: FAILED **");
        $finish;
    end
endmodule
